// File: sv/rlft_pkg.sv
`default_nettype none
package rlft_pkg;

    localparam int W_TIME  = 32;
    localparam int W_COLOR = 24;
    localparam int W_CH    = 8;
    localparam int W_IDX   = 3;
    localparam int W_PROD  = W_CH + 1 + W_TIME;   // (2*mag) * elapsed
    localparam int W_NUM   = W_PROD + 1;          // plus total
    localparam int W_DEN   = W_TIME + 1;          // 2 * total
    localparam int Q_BITS  = W_CH;                // quotient never exceeds mag
    localparam int W_QCNT  = $clog2(Q_BITS);

    // item kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // configuration register indexes
    localparam logic [W_IDX-1:0] CFG_START_COLOR = 3'd0;
    localparam logic [W_IDX-1:0] CFG_END_COLOR   = 3'd1;
    localparam logic [W_IDX-1:0] CFG_TOTAL_TIME  = 3'd2;
    localparam logic [W_IDX-1:0] CFG_ONE_SHOT    = 3'd3;
    localparam logic [W_IDX-1:0] CFG_HOLD        = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

// File: sv/rgb_linear_fade_timer.sv
`default_nettype none
// Channel   | valid         | ready         | payload
// ----------+---------------+---------------+--------------------------------------------
// input     | i_in_valid    | o_in_ready    | i_kind, i_delta_us
// result    | o_out_valid   | i_out_ready   | o_red, o_green, o_blue, o_done_res, o_elapsed_us
// config    | i_cfg_valid   | o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A restart, a held tick, a finished one-shot tick or a zero-delta tick goes
// from the accept and update steps straight to the output step; a tick that moves
// the fade also takes each of the three color channels through the shared divider
// (select, multiply, load, quotient bits, done) between the update and output
// steps. A channel with equal endpoints or a zero total skips the divider.
// Reset (synchronous, active low) clears fade state and loads register defaults.
// The result sits in an output register; a new item is accepted while it waits,
// and the sequencer stalls in its last step until the output slot frees.
module rgb_linear_fade_timer
    import rlft_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input items
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_kind,
    input  wire logic [W_TIME-1:0] i_delta_us,
    // result items
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [W_CH-1:0]   o_red,
    output logic      [W_CH-1:0]   o_green,
    output logic      [W_CH-1:0]   o_blue,
    output logic                   o_done_res,
    output logic      [W_TIME-1:0] o_elapsed_us,
    // configuration writes
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [W_IDX-1:0]  i_cfg_index,
    input  wire logic [W_TIME-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_CHAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // configuration registers
    logic [W_COLOR-1:0] r_start_color;
    logic [W_COLOR-1:0] r_end_color;
    logic [W_TIME-1:0]  r_total;
    logic               r_one_shot;
    logic               r_hold;

    // sequencer and fade state
    logic [2:0]         r_state,    n_state;
    logic [1:0]         r_ch,       n_ch;
    logic               r_kind,     n_kind;
    logic [W_TIME-1:0]  r_delta,    n_delta;
    logic [W_TIME-1:0]  r_elapsed,  n_elapsed;
    logic               r_finished, n_finished;
    logic [W_COLOR-1:0] r_rgb,      n_rgb;
    logic [W_CH-1:0]    r_mag,      n_mag;
    logic               r_up,       n_up;
    logic [W_PROD-1:0]  r_prod,     n_prod;

    // output slot
    logic               r_out_valid, n_out_valid;
    logic [W_COLOR-1:0] r_out_rgb,   n_out_rgb;
    logic               r_out_done,  n_out_done;
    logic [W_TIME-1:0]  r_out_elap,  n_out_elap;

    // shared divider
    logic               div_start;
    logic [W_NUM-1:0]   div_num;
    logic [W_DEN-1:0]   div_den;
    t_div_stat          div_stat;
    logic [Q_BITS-1:0]  div_quot;

    // per-channel views
    logic [W_CH-1:0]    s_b, e_b, new_b;
    logic [W_TIME-1:0]  e0;
    logic [W_TIME:0]    sum;
    logic               at_end;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Take configuration writes; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color <= '0;
            r_end_color   <= '0;
            r_total       <= '0;
            r_one_shot    <= 1'b1;
            r_hold        <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_COLOR: r_start_color <= i_cfg_data[W_COLOR-1:0];
                CFG_END_COLOR:   r_end_color   <= i_cfg_data[W_COLOR-1:0];
                CFG_TOTAL_TIME:  r_total       <= i_cfg_data;
                CFG_ONE_SHOT:    r_one_shot    <= i_cfg_data[0];
                CFG_HOLD:        r_hold        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Select the byte of the channel in work.
    always_comb begin
        unique case (r_ch)
            CH_RED: begin
                s_b = r_start_color[23:16];
                e_b = r_end_color[23:16];
            end
            CH_GREEN: begin
                s_b = r_start_color[15:8];
                e_b = r_end_color[15:8];
            end
            default: begin
                s_b = r_start_color[7:0];
                e_b = r_end_color[7:0];
            end
        endcase
    end

    // Fade position: wrap in loop mode, then add the tick saturating at total.
    assign at_end = (r_elapsed >= r_total);
    assign e0     = at_end ? '0 : r_elapsed;
    assign sum    = {1'b0, e0} + {1'b0, r_delta};

    // Rounded quotient offsets the start value up or down.
    assign new_b = r_up ? (s_b + div_quot) : (s_b - div_quot);

    assign div_start = (r_state == S_LOAD);
    assign div_num   = {1'b0, r_prod} + {{(W_NUM-W_TIME){1'b0}}, r_total};
    assign div_den   = {r_total, 1'b0};

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_kind      = r_kind;
        n_delta     = r_delta;
        n_elapsed   = r_elapsed;
        n_finished  = r_finished;
        n_rgb       = r_rgb;
        n_mag       = r_mag;
        n_up        = r_up;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_rgb   = r_out_rgb;
        n_out_done  = r_out_done;
        n_out_elap  = r_out_elap;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_delta = i_delta_us;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_ch    = CH_RED;
                n_state = S_DONE;
                priority if (r_kind == KIND_RESTART) begin
                    n_finished = 1'b0;
                    n_elapsed  = '0;
                    n_rgb      = r_start_color;
                end else if (r_hold) begin
                    n_state = S_DONE;
                end else if (at_end && r_one_shot) begin
                    n_finished = 1'b1;
                end else if (r_delta == '0) begin
                    n_elapsed = e0;
                end else begin
                    n_elapsed = (sum > {1'b0, r_total}) ? r_total : sum[W_TIME-1:0];
                    n_state   = S_CHAN;
                end
            end
            S_CHAN: begin
                // Equal endpoints keep the channel; zero total jumps to the end.
                n_up  = (s_b < e_b);
                n_mag = (s_b < e_b) ? (e_b - s_b) : (s_b - e_b);
                priority if (s_b == e_b) begin
                    n_state = (r_ch == CH_BLUE) ? S_DONE : S_CHAN;
                    n_ch    = r_ch + 1'b1;
                end else if (r_total == '0) begin
                    unique case (r_ch)
                        CH_RED:   n_rgb[23:16] = e_b;
                        CH_GREEN: n_rgb[15:8]  = e_b;
                        default:  n_rgb[7:0]   = e_b;
                    endcase
                    n_state = (r_ch == CH_BLUE) ? S_DONE : S_CHAN;
                    n_ch    = r_ch + 1'b1;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = W_PROD'({r_mag, 1'b0}) * W_PROD'(r_elapsed);
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    unique case (r_ch)
                        CH_RED:   n_rgb[23:16] = new_b;
                        CH_GREEN: n_rgb[15:8]  = new_b;
                        default:  n_rgb[7:0]   = new_b;
                    endcase
                    n_state = (r_ch == CH_BLUE) ? S_DONE : S_CHAN;
                    n_ch    = r_ch + 1'b1;
                end
            end
            S_DONE: begin
                // Hold here until the output slot is free or being emptied.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_rgb   = r_rgb;
                    n_out_done  = r_finished;
                    n_out_elap  = r_elapsed;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= CH_RED;
            r_elapsed   <= '0;
            r_finished  <= 1'b0;
            r_rgb       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_elapsed   <= n_elapsed;
            r_finished  <= n_finished;
            r_rgb       <= n_rgb;
            r_out_valid <= n_out_valid;
        end
        r_kind     <= n_kind;
        r_delta    <= n_delta;
        r_mag      <= n_mag;
        r_up       <= n_up;
        r_prod     <= n_prod;
        r_out_rgb  <= n_out_rgb;
        r_out_done <= n_out_done;
        r_out_elap <= n_out_elap;
    end

    rlft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_out_rgb[23:16];
    assign o_green      = r_out_rgb[15:8];
    assign o_blue       = r_out_rgb[7:0];
    assign o_done_res   = r_out_done;
    assign o_elapsed_us = r_out_elap;

endmodule
`default_nettype wire

// File: sv/rlft_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, MSB first.
// Caller guarantees the quotient fits in Q_BITS.
module rlft_div
    import rlft_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W_NUM-1:0]  i_num,
    input  wire logic [W_DEN-1:0]  i_den,
    output t_div_stat              o_stat,
    output logic      [Q_BITS-1:0] o_quot
);

    localparam int W_DSH = W_DEN + Q_BITS - 1;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [W_QCNT-1:0] r_cnt,  n_cnt;
    logic [W_NUM-1:0]  r_rem,  n_rem;
    logic [W_DSH-1:0]  r_dsh,  n_dsh;
    logic [Q_BITS-1:0] r_q,    n_q;
    logic              ge;

    assign ge = (r_rem >= {{(W_NUM-W_DSH){1'b0}}, r_dsh});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_dsh  = {i_den, {(Q_BITS-1){1'b0}}};
            n_q    = '0;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - {{(W_NUM-W_DSH){1'b0}}, r_dsh};
            end
            n_q   = {r_q[Q_BITS-2:0], ge};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == W_QCNT'(Q_BITS-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule
`default_nettype wire

// File: sv/rlft_chk.sv
`default_nettype none
module rlft_chk
    import rlft_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              i_kind,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [W_CH-1:0]   o_red,
    input wire logic [W_CH-1:0]   o_green,
    input wire logic [W_CH-1:0]   o_blue,
    input wire logic              o_done_res,
    input wire logic [W_TIME-1:0] o_elapsed_us
);

    logic       r_last_kind;
    logic [1:0] r_outst;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_kind <= KIND_TICK;
            r_outst     <= '0;
        end else begin
            if (in_acc) begin
                r_last_kind <= i_kind;
            end
            r_outst <= r_outst + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_elapsed_us) && $stable(o_done_res) && $stable(o_red)
            && $stable(o_green) && $stable(o_blue))
        else $error("result changed while stalled");

    // One item at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("accepted a second item while busy");

    // Results match items: never more than one pending plus one in work.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outst != 2'd3) && (!o_out_valid || r_outst != 2'd0))
        else $error("result count out of step with items");

    // A freshly shown result after a restart starts the fade over.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (!$past(o_out_valid) || $past(i_out_ready))
            && r_last_kind == KIND_RESTART
            |-> o_elapsed_us == '0 && !o_done_res)
        else $error("restart result not cleared");

endmodule

bind rgb_linear_fade_timer rlft_chk u_rlft_chk (.*);
`default_nettype wire
